[rtl/core/tles_pkg.sv]
// types, codes and helper functions of the traffic light emergency sequencer
package tles_pkg;

    localparam int unsigned TimeW = 16;
    localparam int unsigned PhaseW = 3;
    localparam int unsigned DirW = 2;
    localparam int unsigned CfgIdxW = 3;

    // extra walk ticks granted before an emergency green
    localparam logic [TimeW-1:0] WALK_EXTENSION = TimeW'(1000);
    localparam int unsigned BUZZER_PERIOD_DEF = 500;

    // lamp codes
    typedef logic [1:0] lamp_t;
    localparam lamp_t LAMP_RED = 2'd0;
    localparam lamp_t LAMP_YELLOW = 2'd1;
    localparam lamp_t LAMP_GREEN = 2'd2;

    // input opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // normal-cycle sub steps
    localparam logic [1:0] SUB_YELLOW_IN = 2'd0;
    localparam logic [1:0] SUB_GREEN = 2'd1;
    localparam logic [1:0] SUB_YELLOW_OUT = 2'd2;

    localparam logic [PhaseW-1:0] PHASE_WALK = 3'd0;
    localparam logic [PhaseW-1:0] PHASE_LAST = 3'd4;

    // sequencer mode, one-hot
    typedef enum logic [3:0] {
        MODE_NORMAL       = 4'b0001,
        MODE_TRANSITION   = 4'b0010,
        MODE_EMERG_GREEN  = 4'b0100,
        MODE_EMERG_YELLOW = 4'b1000
    } mode_t;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_GREEN_NORTH    = 3'd0,
        REG_GREEN_SOUTH    = 3'd1,
        REG_GREEN_WEST     = 3'd2,
        REG_GREEN_EAST     = 3'd3,
        REG_YELLOW_TIME    = 3'd4,
        REG_WALK_TIME      = 3'd5,
        REG_EMERGENCY_TIME = 3'd6
    } cfg_reg_t;

    // everything shown on the result channel but the buzzer
    typedef struct packed {
        lamp_t north;
        lamp_t south;
        lamp_t west;
        lamp_t east;
        logic  walk;
        logic  active;
    } lamp_set_t;

    function automatic logic is_walking(mode_t mode, logic [PhaseW-1:0] phase);
        return (phase == PHASE_WALK) &&
               ((mode == MODE_NORMAL) || (mode == MODE_TRANSITION));
    endfunction

    function automatic lamp_set_t lamps_of(mode_t mode, logic [PhaseW-1:0] phase,
                                           logic [1:0] sub, logic [DirW-1:0] pend);
        lamp_t [3:0] lamp;
        lamp_set_t   res;
        logic [PhaseW-1:0] dir_idx;
        lamp = {4{LAMP_RED}};
        dir_idx = phase - 3'd1;
        if (mode == MODE_EMERG_GREEN) begin
            lamp[pend] = LAMP_GREEN;
        end else if (mode == MODE_EMERG_YELLOW) begin
            lamp[pend] = LAMP_YELLOW;
        end else if ((phase != PHASE_WALK) && (phase <= PHASE_LAST)) begin
            lamp[dir_idx[DirW-1:0]] = ((mode == MODE_NORMAL) && (sub == SUB_GREEN))
                                      ? LAMP_GREEN : LAMP_YELLOW;
        end
        res.north = lamp[0];
        res.south = lamp[1];
        res.west = lamp[2];
        res.east = lamp[3];
        res.walk = is_walking(mode, phase);
        res.active = (mode != MODE_NORMAL);
        return res;
    endfunction

    // phase that follows an emergency for a direction: east wraps to walk
    function automatic logic [PhaseW-1:0] resume_phase(logic [DirW-1:0] dir);
        logic [PhaseW-1:0] res;
        res = PHASE_WALK;
        case (dir)
            2'd0: res = 3'd2;
            2'd1: res = 3'd3;
            2'd2: res = 3'd4;
            default: res = PHASE_WALK;
        endcase
        return res;
    endfunction

endpackage

[rtl/core/traffic_light_emergency_sequencer_unit.sv]
// four-way traffic light sequencer with emergency override
//
// input channel (s_valid/s_ready): one transfer per item; s_opcode 0 is a
//   1 ms tick, 1 is an emergency request for s_direction
// result channel (m_valid/m_ready): exactly one result per input transfer,
//   lamps of all four directions, walk light, buzzer pulse, emergency flag
// config channel (cfg_valid/cfg_ready): cfg_index selects one of seven
//   16-bit duration registers, cfg_data is written; always ready, writes
//   are expected only while the block is idle
// timing: the result is registered and shows in the cycle after the input
//   transfer; throughput is one item per cycle while m_ready keeps up, the whole
//   step is a single compare-and-update of the timer and the phase registers
// stall: while a result waits with m_ready low, s_ready drops; a new item
//   is taken in the same cycle the waiting result is taken
// reset (aresetn low, synchronous): normal mode, walk phase, timers
//   cleared, durations back to defaults, result channel empty
module traffic_light_emergency_sequencer_unit
    import tles_pkg::*;
#(
    parameter int unsigned BUZZER_PERIOD = BUZZER_PERIOD_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [DirW-1:0]    s_direction,

    output logic               m_valid,
    input  logic               m_ready,
    output lamp_t              m_north_lamp,
    output lamp_t              m_south_lamp,
    output lamp_t              m_west_lamp,
    output lamp_t              m_east_lamp,
    output logic               m_walk_on,
    output logic               m_buzzer_pulse,
    output logic               m_emergency_active,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [TimeW-1:0]   cfg_data
);

    // buzzer counter holds 0 .. period-1
    localparam int unsigned BuzzW = (BUZZER_PERIOD > 1) ? $clog2(BUZZER_PERIOD) : 1;
    localparam logic [BuzzW-1:0] BuzzLast = BuzzW'(BUZZER_PERIOD - 1);

    // duration registers
    logic [TimeW-1:0] green_north_reg, green_south_reg, green_west_reg, green_east_reg;
    logic [TimeW-1:0] yellow_time_reg, walk_time_reg, emergency_time_reg;

    // sequencer state
    mode_t             mode_reg, mode_next;
    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [1:0]        sub_reg, sub_next;
    logic [DirW-1:0]   pend_reg, pend_next;
    logic [TimeW-1:0]  tick_reg, tick_next;
    logic [BuzzW-1:0]  buzz_reg, buzz_next;

    // result register
    logic      m_valid_reg, m_valid_next;
    lamp_set_t lamps_reg;
    logic      pulse_reg;

    lamp_set_t        lamps_now;
    logic             pulse_now;
    logic             in_xfer;
    logic             walk_now;
    logic [TimeW-1:0] duration;
    logic [TimeW-1:0] green_sel;
    logic [TimeW:0]   tick_sum;
    logic [PhaseW-1:0] dir_of_phase;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // config writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            green_north_reg <= TimeW'(5000);
            green_south_reg <= TimeW'(5000);
            green_west_reg <= TimeW'(5000);
            green_east_reg <= TimeW'(5000);
            yellow_time_reg <= TimeW'(1000);
            walk_time_reg <= TimeW'(5000);
            emergency_time_reg <= TimeW'(5000);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_GREEN_NORTH: green_north_reg <= cfg_data;
                REG_GREEN_SOUTH: green_south_reg <= cfg_data;
                REG_GREEN_WEST: green_west_reg <= cfg_data;
                REG_GREEN_EAST: green_east_reg <= cfg_data;
                REG_YELLOW_TIME: yellow_time_reg <= cfg_data;
                REG_WALK_TIME: walk_time_reg <= cfg_data;
                REG_EMERGENCY_TIME: emergency_time_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // green time of the direction the current phase serves
    assign dir_of_phase = phase_reg - 3'd1;
    always_comb begin
        case (dir_of_phase[DirW-1:0])
            2'd0: green_sel = green_north_reg;
            2'd1: green_sel = green_south_reg;
            2'd2: green_sel = green_west_reg;
            default: green_sel = green_east_reg;
        endcase
    end

    // length of the running step
    always_comb begin
        unique case (mode_reg)
            MODE_TRANSITION:
                duration = (phase_reg == PHASE_WALK) ? WALK_EXTENSION : yellow_time_reg;
            MODE_EMERG_GREEN: duration = emergency_time_reg;
            MODE_EMERG_YELLOW: duration = yellow_time_reg;
            default: begin
                if (phase_reg == PHASE_WALK) begin
                    duration = walk_time_reg;
                end else if (sub_reg == SUB_GREEN) begin
                    duration = green_sel;
                end else begin
                    duration = yellow_time_reg;
                end
            end
        endcase
    end

    assign walk_now = is_walking(mode_reg, phase_reg);
    assign tick_sum = {1'b0, tick_reg} + 17'd1;

    // one step of the sequencer
    always_comb begin
        mode_next = mode_reg;
        phase_next = phase_reg;
        sub_next = sub_reg;
        pend_next = pend_reg;
        tick_next = tick_reg;
        buzz_next = buzz_reg;
        pulse_now = 1'b0;

        if (s_opcode == OP_REQUEST) begin
            // requests only count in a normal phase
            if (mode_reg == MODE_NORMAL) begin
                pend_next = s_direction;
                tick_next = '0;
                if ((phase_reg == PHASE_WALK) || (sub_reg == SUB_GREEN)) begin
                    mode_next = MODE_TRANSITION;
                end else begin
                    mode_next = MODE_EMERG_GREEN;
                    buzz_next = '0;
                end
            end
            lamps_now = lamps_of(mode_next, phase_next, sub_next, pend_next);
        end else begin
            lamps_now = lamps_of(mode_reg, phase_reg, sub_reg, pend_reg);
            // buzzer counts walk ticks only
            if (walk_now) begin
                if (buzz_reg >= BuzzLast) begin
                    pulse_now = 1'b1;
                    buzz_next = '0;
                end else begin
                    buzz_next = buzz_reg + 1'b1;
                end
            end else begin
                buzz_next = '0;
            end

            if (tick_sum >= {1'b0, duration}) begin
                tick_next = '0;
                unique case (mode_reg)
                    MODE_TRANSITION: mode_next = MODE_EMERG_GREEN;
                    MODE_EMERG_GREEN: mode_next = MODE_EMERG_YELLOW;
                    MODE_EMERG_YELLOW: begin
                        mode_next = MODE_NORMAL;
                        phase_next = resume_phase(pend_reg);
                        sub_next = SUB_YELLOW_IN;
                    end
                    default: begin
                        if ((phase_reg == PHASE_WALK) || (sub_reg >= SUB_YELLOW_OUT)) begin
                            phase_next = (phase_reg >= PHASE_LAST) ? PHASE_WALK
                                                                   : phase_reg + 3'd1;
                            sub_next = SUB_YELLOW_IN;
                        end else begin
                            sub_next = sub_reg + 2'd1;
                        end
                    end
                endcase
            end else begin
                tick_next = tick_sum[TimeW-1:0];
            end

            if (!is_walking(mode_next, phase_next)) begin
                buzz_next = '0;
            end
        end
    end

    // state advances on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            phase_reg <= PHASE_WALK;
            sub_reg <= SUB_YELLOW_IN;
            pend_reg <= '0;
            tick_reg <= '0;
            buzz_reg <= '0;
        end else if (in_xfer) begin
            mode_reg <= mode_next;
            phase_reg <= phase_next;
            sub_reg <= sub_next;
            pend_reg <= pend_next;
            tick_reg <= tick_next;
            buzz_reg <= buzz_next;
        end
    end

    // result register, refilled in the cycle its content is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_xfer) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            lamps_reg <= lamps_now;
            pulse_reg <= pulse_now;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_north_lamp = lamps_reg.north;
    assign m_south_lamp = lamps_reg.south;
    assign m_west_lamp = lamps_reg.west;
    assign m_east_lamp = lamps_reg.east;
    assign m_walk_on = lamps_reg.walk;
    assign m_buzzer_pulse = pulse_reg;
    assign m_emergency_active = lamps_reg.active;

`ifndef SYNTHESIS
    // never more than one car direction off red
    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_north_lamp != LAMP_RED, m_south_lamp != LAMP_RED,
                                m_west_lamp != LAMP_RED, m_east_lamp != LAMP_RED}) <= 1)
        else $error("more than one direction shows a car lamp");

    // walk only with every car lamp red
    a_walk_all_red: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_walk_on) |-> (m_north_lamp == LAMP_RED && m_south_lamp == LAMP_RED
                                    && m_west_lamp == LAMP_RED && m_east_lamp == LAMP_RED))
        else $error("walk on while a car lamp is lit");

    // buzzer sounds only during walk
    a_buzz_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_buzzer_pulse) |-> m_walk_on)
        else $error("buzzer pulse outside walk");

    // a taken result with no new transfer empties the result register
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !(s_valid && s_ready)) |=> !m_valid)
        else $error("result repeated after transfer");
`endif

endmodule
